>>> design/tvas_pkg.sv
`default_nettype none
package tvas_pkg;

  localparam int REG_AW   = 5;
  localparam int REG_DEPTH = 32;
  localparam int TM_W     = 34;
  localparam int DIVN_W   = 50;
  localparam int DIVD_W   = 34;
  localparam int ACC_W    = 56;
  localparam int SR_W     = 18;
  localparam int MS_W     = 15;

  localparam logic [REG_AW-1:0] VOL_REG        = 5'd24;
  localparam logic [REG_AW-1:0] REG_COUNT      = 5'd25;
  localparam logic [5:0]        VOICE_REGS_END = 6'd21;
  localparam logic [7:0]        VOL_RESET      = 8'd8;
  localparam logic [23:0]       COUNT_MAX      = 24'hFFFFFF;
  localparam logic [17:0]       MIX_RECIP      = 18'd139811;

  typedef enum logic [1:0] {
    WV_TRI = 2'd0,
    WV_SAW = 2'd1,
    WV_PUL = 2'd2,
    WV_NOI = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADS  = 2'd1,
    ST_REL  = 2'd2
  } stage_t;

  typedef struct packed {
    logic [23:0] phase;
    wave_t       wave;
    stage_t      stage;
    logic [23:0] count;
    logic [15:0] hold;
  } vstate_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [MS_W-1:0] attack_ms(input logic [3:0] i);
    logic [MS_W-1:0] r;
    unique case (i)
      4'd0:  r = 15'd2;
      4'd1:  r = 15'd8;
      4'd2:  r = 15'd16;
      4'd3:  r = 15'd24;
      4'd4:  r = 15'd38;
      4'd5:  r = 15'd56;
      4'd6:  r = 15'd68;
      4'd7:  r = 15'd80;
      4'd8:  r = 15'd100;
      4'd9:  r = 15'd250;
      4'd10: r = 15'd500;
      4'd11: r = 15'd800;
      4'd12: r = 15'd1000;
      4'd13: r = 15'd3000;
      4'd14: r = 15'd5000;
      4'd15: r = 15'd8000;
    endcase
    return r;
  endfunction

  function automatic logic [MS_W-1:0] decrel_ms(input logic [3:0] i);
    logic [MS_W-1:0] r;
    unique case (i)
      4'd0:  r = 15'd6;
      4'd1:  r = 15'd24;
      4'd2:  r = 15'd48;
      4'd3:  r = 15'd72;
      4'd4:  r = 15'd114;
      4'd5:  r = 15'd168;
      4'd6:  r = 15'd204;
      4'd7:  r = 15'd240;
      4'd8:  r = 15'd300;
      4'd9:  r = 15'd750;
      4'd10: r = 15'd1500;
      4'd11: r = 15'd2400;
      4'd12: r = 15'd3000;
      4'd13: r = 15'd9000;
      4'd14: r = 15'd15000;
      4'd15: r = 15'd24000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/three_voice_adsr_synth.sv
// Three-voice envelope synthesizer. Input transfers with in_tuser low write
// register in_tdata[4:0] (voices 0-20, volume 24) with in_tdata[12:5] and
// produce no result. A transfer with in_tuser high produces one 8-bit
// sample on the output (127 is silence). Voice state and the register file
// sit in single-port-read memories; a sample walks the voices one at a time,
// fetching seven register bytes per voice, forming the phase increment by a
// reciprocal multiply in low and high halves and running at most one envelope
// division in a 50-step serial divider; the mix is scaled by a reciprocal
// multiply. A noise voice skips the increment multiply, and a voice whose
// envelope holds or has decayed to zero skips the division. in_tready returns
// together with out_tvalid, once the output register is free. After reset a
// clearing pass loads the register file and voice state; in_tready is low
// meanwhile.
`default_nettype none
module three_voice_adsr_synth
  import tvas_pkg::*;
#(
  parameter int SAMPLE_RATE = 44100,
  parameter int CLOCK_RATE  = 1000000,
  parameter int NUM_VOICES  = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_address[4:0], write_value[12:5]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // sample[7:0]
);
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VSW = $bits(vstate_t);
  localparam longint INC_M = ((longint'(CLOCK_RATE) <<< 35) + longint'(SAMPLE_RATE) - 1)
                             / longint'(SAMPLE_RATE);
  localparam logic [21:0] INC_ML = 22'(INC_M);
  localparam logic [21:0] INC_MH = 22'(INC_M >>> 22);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FETCH, S_PREP, S_WAVE, S_IDIV, S_IWAIT, S_EMUL,
    S_EDIV, S_EWAIT, S_EFIN, S_ACC, S_VOL, S_MIX, S_QDIV, S_QWAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    EM_DIVP, EM_DIVD, EM_HOLD, EM_ZERO
  } emode_t;

  state_t                   state_r;
  logic [REG_AW-1:0]        clr_r;
  logic [VW-1:0]            v_r;
  logic [5:0]               vbase_r;
  logic [2:0]               k_r;
  logic                     inr_r;
  logic [7:0]               vr_r [7];
  logic [23:0]              ph_r;
  wave_t                    ws_r;
  stage_t                   st_r;
  logic [23:0]              cnt_r;
  logic [15:0]              hold_r;
  logic                     gate_r;
  logic [TM_W-1:0]          a_r;
  logic [TM_W-1:0]          d_r;
  logic [3:0]               sus_r;
  logic [TM_W-1:0]          tm_r;
  logic signed [32:0]       y_r;
  emode_t                   mode_r;
  logic [DIVN_W-1:0]        num_r;
  logic [TM_W-1:0]          dv_r;
  logic [15:0]              e_r;
  logic signed [ACC_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic                     neg_r;
  logic [12:0]              q_r;
  logic [37:0]              inc_lo_r;
  logic [7:0]               res_r;
  logic                     out_valid_r;
  logic [7:0]               out_data_r;
  logic [22:0]              lfsr_r;

  logic                     rram_we;
  logic [REG_AW-1:0]        rram_waddr;
  logic [7:0]               rram_wdata;
  logic [REG_AW-1:0]        rram_raddr;
  logic [7:0]               rram_rdata;
  logic                     vram_we;
  logic [VW-1:0]            vram_waddr;
  vstate_t                  vram_wdata;
  logic [VSW-1:0]           vram_rdata;
  vstate_t                  vst;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     acc_in;
  logic [5:0]               idx6;
  logic [7:0]               ctrl;
  logic                     gate;
  wave_t                    ws_new;
  stage_t                   st_new;
  logic [23:0]              cnt_new;
  logic [23:0]              cnt_base;
  logic [TM_W-1:0]          a_new;
  logic [TM_W-1:0]          d_new;
  logic [11:0]              pw;
  logic [15:0]              freq;
  logic [37:0]              inc_hi;
  logic [38:0]              inc_sum;
  logic [22:0]              lfsr_n;
  logic signed [35:0]       p36;
  logic signed [35:0]       y36;
  logic                     pul_hi;
  logic [16:0]              mul_a;
  logic [TM_W-1:0]          mul_b;
  logic [50:0]              mprod;
  emode_t                   mode_new;
  logic [DIVN_W-1:0]        num_new;
  logic [TM_W-1:0]          dv_new;
  logic [16:0]              e17;
  logic [15:0]              e16;
  logic [15:0]              hold_new;
  logic [23:0]              cnt_fin;
  logic signed [49:0]       ye;
  logic signed [ACC_W-1:0]  mixp;
  logic signed [15:0]       s16;
  logic [16:0]              qd;
  logic [34:0]              qprod;
  logic signed [13:0]       qres;

  localparam logic signed [35:0] AMP  = 36'sd2130706432;
  localparam logic signed [35:0] AMP3 = 36'sd6392119296;

  tvas_ram #(.WIDTH(8), .DEPTH(REG_DEPTH)) u_rram (
    .clk   (clk),
    .we    (rram_we),
    .waddr (rram_waddr),
    .wdata (rram_wdata),
    .raddr (rram_raddr),
    .rdata (rram_rdata)
  );

  tvas_ram #(.WIDTH(VSW), .DEPTH(NUM_VOICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (v_r),
    .rdata (vram_rdata)
  );

  tvas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign acc_in     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign idx6       = vbase_r + {3'b000, k_r};
  assign vst        = vstate_t'(vram_rdata);

  always_comb begin
    rram_we    = 1'b0;
    rram_waddr = in_tdata[4:0];
    rram_wdata = in_tdata[12:5];
    if (state_r == S_CLR) begin
      rram_we    = 1'b1;
      rram_waddr = clr_r;
      rram_wdata = (clr_r == VOL_REG) ? VOL_RESET : 8'd0;
    end else if (acc_in && !in_tuser && (in_tdata[4:0] < REG_COUNT)) begin
      rram_we = 1'b1;
    end
    rram_raddr = (state_r == S_VOL) ? VOL_REG : idx6[REG_AW-1:0];
  end

  always_comb begin
    ctrl = vr_r[4];
    gate = ctrl[0];
    ws_new = ws_r;
    if (ctrl[4]) ws_new = WV_TRI;
    if (ctrl[5]) ws_new = WV_SAW;
    if (ctrl[6]) ws_new = WV_PUL;
    if (ctrl[7]) ws_new = WV_NOI;
    if (gate) begin
      st_new   = ST_ADS;
      cnt_base = (st_r != ST_ADS) ? 24'd0 : cnt_r;
      cnt_new  = (cnt_base < COUNT_MAX) ? cnt_base + 24'd1 : cnt_base;
    end else begin
      st_new   = ST_REL;
      cnt_base = (st_r != ST_REL) ? 24'd0 : cnt_r;
      cnt_new  = cnt_base;
    end
    a_new = TM_W'({19'd0, attack_ms(vr_r[5][7:4])} * TM_W'(SR_W'(SAMPLE_RATE)));
    d_new = TM_W'({19'd0, decrel_ms(gate ? vr_r[5][3:0] : vr_r[6][3:0])}
                  * TM_W'(SR_W'(SAMPLE_RATE)));
    pw   = {vr_r[3][3:0], vr_r[2]};
    freq = {vr_r[1], vr_r[0]};
    inc_hi  = {22'd0, freq} * {16'd0, INC_MH};
    inc_sum = {1'b0, inc_hi} + {23'd0, inc_lo_r[37:22]};
  end

  always_comb begin
    lfsr_n = {lfsr_r[21:0], lfsr_r[22] ^ lfsr_r[17]};
    p36    = $signed({12'd0, ph_r});
    pul_hi = ({12'd0, ph_r} * 36'd4095) < {pw, 24'd0};
    case (ws_r)
      WV_TRI:  y36 = ph_r[23] ? (AMP3 - p36 * 36'sd508) : (p36 * 36'sd508 - AMP);
      WV_SAW:  y36 = AMP - p36 * 36'sd254;
      WV_PUL:  y36 = pul_hi ? AMP : -AMP;
      default: y36 = ($signed({28'd0, lfsr_n[7:0]}) - 36'sd127) <<< 24;
    endcase
  end

  always_comb begin
    mul_a = gate_r ? (17'd65536 - {1'b0, sus_r, 12'd0}) : {13'd0, sus_r};
    mul_b = gate_r ? (tm_r - a_r) : (d_r - tm_r);
    mprod = {34'd0, mul_a} * {17'd0, mul_b};
    mode_new = EM_ZERO;
    num_new  = {tm_r, 16'd0};
    dv_new   = d_r;
    if (gate_r) begin
      if (tm_r < a_r) begin
        mode_new = EM_DIVP;
        dv_new   = a_r;
      end else if ({1'b0, tm_r} < ({1'b0, a_r} + {1'b0, d_r})) begin
        mode_new = EM_DIVD;
        num_new  = mprod[DIVN_W-1:0];
      end else begin
        mode_new = EM_HOLD;
      end
    end else if (tm_r < d_r) begin
      mode_new = EM_DIVP;
      num_new  = DIVN_W'({mprod, 12'd0});
    end
  end

  always_comb begin
    case (mode_r)
      EM_DIVP: e17 = div_rsp.quot[16:0];
      EM_DIVD: e17 = 17'd65536 - div_rsp.quot[16:0];
      EM_HOLD: e17 = {1'b0, hold_r};
      default: e17 = 17'd0;
    endcase
    e16      = e17[16] ? 16'hFFFF : e17[15:0];
    hold_new = gate_r ? e16 : hold_r;
    cnt_fin  = (gate_r || (cnt_r == COUNT_MAX)) ? cnt_r : cnt_r + 24'd1;
    vram_wdata.phase = ph_r;
    vram_wdata.wave  = ws_r;
    vram_wdata.stage = st_r;
    vram_wdata.count = cnt_fin;
    vram_wdata.hold  = hold_new;
    vram_we    = 1'b0;
    vram_waddr = v_r;
    if (state_r == S_CLR) begin
      vram_wdata.phase = 24'd0;
      vram_wdata.wave  = WV_SAW;
      vram_wdata.stage = ST_IDLE;
      vram_wdata.count = 24'd0;
      vram_wdata.hold  = 16'd0;
      vram_we    = (32'(clr_r) < NUM_VOICES);
      vram_waddr = VW'(clr_r);
    end else if (state_r == S_EFIN) begin
      vram_we = 1'b1;
    end
  end

  always_comb begin
    ye    = y_r * $signed({1'b0, e_r});
    mixp  = sum_r * $signed({1'b0, rram_rdata[3:0]});
    s16   = prod_r[ACC_W-1:40];
    qd    = s16[15] ? (17'(-$signed({s16[15], s16})) + 17'd29) : {1'b0, s16};
    qprod = {18'd0, qd} * {17'd0, MIX_RECIP};
    qres  = neg_r ? (14'sd127 - $signed({3'd0, q_r[10:0]}))
                  : (14'sd127 + $signed({3'd0, q_r[10:0]}));
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = num_r;
    div_req.divisor  = dv_r;
    case (state_r)
      S_EDIV: begin
        div_req.start = (mode_r == EM_DIVP) || (mode_r == EM_DIVD);
        if (mode_r == EM_DIVD) begin
          div_req.dividend = num_r + DIVN_W'(dv_r) - DIVN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      lfsr_r      <= '1;
      v_r         <= '0;
      k_r         <= '0;
      vbase_r     <= '0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc_in && in_tuser) begin
            v_r     <= '0;
            vbase_r <= '0;
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          inr_r <= idx6 < VOICE_REGS_END;
          if (k_r != 3'd0) vr_r[3'(k_r - 3'd1)] <= inr_r ? rram_rdata : 8'd0;
          if (k_r == 3'd7) begin
            ph_r    <= vst.phase;
            ws_r    <= vst.wave;
            st_r    <= vst.stage;
            cnt_r   <= vst.count;
            hold_r  <= vst.hold;
            state_r <= S_PREP;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_PREP: begin
          ws_r    <= ws_new;
          st_r    <= st_new;
          cnt_r   <= cnt_new;
          gate_r  <= gate;
          a_r     <= a_new;
          d_r     <= d_new;
          sus_r   <= vr_r[6][7:4];
          state_r <= S_WAVE;
        end
        S_WAVE: begin
          y_r  <= y36[32:0];
          tm_r <= TM_W'({10'd0, cnt_r} * 34'd1000);
          if (ws_r == WV_NOI) begin
            lfsr_r  <= lfsr_n;
            state_r <= S_EMUL;
          end else begin
            state_r <= S_IDIV;
          end
        end
        S_IDIV: begin
          inc_lo_r <= {22'd0, freq} * {16'd0, INC_ML};
          state_r  <= S_IWAIT;
        end
        S_IWAIT: begin
          ph_r    <= ph_r + inc_sum[36:13];
          state_r <= S_EMUL;
        end
        S_EMUL: begin
          mode_r  <= mode_new;
          num_r   <= num_new;
          dv_r    <= dv_new;
          state_r <= S_EDIV;
        end
        S_EDIV: begin
          state_r <= (mode_r == EM_DIVP || mode_r == EM_DIVD) ? S_EWAIT : S_EFIN;
        end
        S_EWAIT: if (div_rsp.done) state_r <= S_EFIN;
        S_EFIN: begin
          e_r     <= e16;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_r + ACC_W'(ye);
          k_r   <= '0;
          if (v_r == VW'(NUM_VOICES - 1)) begin
            state_r <= S_VOL;
          end else begin
            v_r     <= v_r + 1'b1;
            vbase_r <= vbase_r + 6'd7;
            state_r <= S_FETCH;
          end
        end
        S_VOL: state_r <= S_MIX;
        S_MIX: begin
          prod_r  <= mixp;
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          neg_r   <= s16[15];
          q_r     <= qprod[34:22];
          state_r <= S_QWAIT;
        end
        S_QWAIT: begin
          if (qres > 14'sd255) begin
            res_r <= 8'd255;
          end else if (qres < 14'sd0) begin
            res_r <= 8'd0;
          end else begin
            res_r <= qres[7:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_vram_addr: assert property (@(posedge clk) disable iff (!rst_n)
    vram_we |-> (32'(vram_waddr) < NUM_VOICES))
    else $error("voice write out of range");
  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("transfer taken during sample");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_EWAIT))
    else $error("quotient with no waiter");
`endif

endmodule
`default_nettype wire

>>> design/tvas_ram.sv
`default_nettype none
module tvas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/tvas_div.sv
`default_nettype none
module tvas_div
  import tvas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CW = $clog2(DIVN_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIVN_W-1:0] dvd_r;
  logic [DIVD_W-1:0] dvs_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W:0]   trial;
  logic              take;

  assign trial = {rem_r, dvd_r[DIVN_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? DIVD_W'(trial - {1'b0, dvs_r}) : trial[DIVD_W-1:0];
        dvd_r <= {dvd_r[DIVN_W-2:0], take};
        if (cnt_r == CW'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
endmodule
`default_nettype wire
